/* hw/rtl/gmps_pkg.sv */
// ----------------------------------------------------------------------------
// gmps_pkg
// Shared constants, types and helpers of the grid maximum path sum block.
// ----------------------------------------------------------------------------
package gmps_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 256;
    localparam int VALUE_BITS  = 16;
    localparam int SUM_BITS    = 25;
    localparam int CFG_BITS    = 9;
    localparam int CFG_IDX_BITS = 1;

    localparam int COL_BITS = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_BITS = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    // Wide enough to hold a count up to the larger maximum itself.
    localparam int CNT_BITS = $clog2(((MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS) + 1);

    localparam int QUEUE_DEPTH = 3;
    localparam int QCNT_BITS   = 2;

    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ROW_COUNT    = 1'b0,
        REG_COLUMN_COUNT = 1'b1
    } t_cfg_reg;

    // Work of one cell in the read-modify-write stage.
    typedef struct packed {
        logic                  valid;
        logic [VALUE_BITS-1:0] value;
        logic [COL_BITS-1:0]   addr;
        logic                  first_row;
        logic                  first_col;
        logic                  last;
        logic                  fwd;
    } t_s1;

    // A count of zero acts as one, and a count above the limit acts as the limit.
    function automatic logic [CNT_BITS-1:0] eff_count(input logic [CFG_BITS-1:0] raw,
                                                      input logic [CNT_BITS-1:0] limit);
        logic [CNT_BITS:0] raw_w;
        logic [CNT_BITS:0] lim_w;
        logic [CNT_BITS-1:0] res;
        raw_w = (CNT_BITS + 1)'(raw);
        lim_w = (CNT_BITS + 1)'(limit);
        if (raw == '0) begin
            res = CNT_BITS'(1);
        end else if (raw_w > lim_w) begin
            res = limit;
        end else begin
            res = raw_w[CNT_BITS-1:0];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/gmps_ram.sv */
// ----------------------------------------------------------------------------
// gmps_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module gmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]          i_wdata,
    input  logic                      i_re,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/grid_max_path_sum.sv */
// ----------------------------------------------------------------------------
// grid_max_path_sum
// Streaming maximum right/down path sum over a grid given in raster order.
// ----------------------------------------------------------------------------
// Usage:
// Cell values arrive one per request on the input channel (i_valid, o_stall,
// i_gift_value), row by row from the top-left cell. After the bottom-right
// cell of each grid, one request leaves on the output channel (o_valid,
// i_stall, o_best_total) carrying the largest path sum of that grid.
// The grid size is set through the write port (i_cfg_we, i_cfg_index,
// i_cfg_data); any write restarts the grid at the top-left cell. The user
// must make writes only while the block is idle; the block does not enforce it.
// Throughput is one cell per clock while o_stall is low, bounded by the single
// read and single write of the row buffer RAM per cell. o_valid rises once the
// last cell of a grid is accepted and has passed r_s1 and the result queue:
// the RAM read returns in r_s1, the add follows at once, and the sum is queued.
// A three-entry result queue decouples the output: cells keep flowing while
// a result waits, and o_stall rises only when another result could not fit.
// Reset (synchronous, active low) clears the counters, the pipeline and the
// queue, and sets both counts to one. The row buffer is not cleared; the
// first row of every grid writes it before any read of it is used.
// ----------------------------------------------------------------------------
module grid_max_path_sum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [gmps_pkg::VALUE_BITS-1:0]     i_gift_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [gmps_pkg::SUM_BITS-1:0]       o_best_total,
    input  logic                                i_cfg_we,
    input  logic [gmps_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [gmps_pkg::CFG_BITS-1:0]       i_cfg_data
);

    localparam int SB = gmps_pkg::SUM_BITS;
    localparam int CB = gmps_pkg::COL_BITS;
    localparam int RB = gmps_pkg::ROW_BITS;
    localparam int NB = gmps_pkg::CNT_BITS;
    localparam int QB = gmps_pkg::QCNT_BITS;
    localparam int QD = gmps_pkg::QUEUE_DEPTH;

    // Configuration and position within the grid.
    logic [gmps_pkg::CFG_BITS-1:0] r_row_count;
    logic [gmps_pkg::CFG_BITS-1:0] r_col_count;
    logic [RB-1:0]                 r_row;
    logic [CB-1:0]                 r_col;
    logic [RB-1:0]                 n_row;
    logic [CB-1:0]                 n_col;

    // Read-modify-write stage and running best of the cell to the left.
    gmps_pkg::t_s1                 r_s1;
    gmps_pkg::t_s1                 n_s1;
    logic [SB-1:0]                 r_last_best;

    // Result queue, head at entry zero.
    logic [SB-1:0]                 r_q [QD];
    logic [SB-1:0]                 n_q [QD];
    logic [QB-1:0]                 r_q_count;
    logic [QB-1:0]                 n_q_count;

    logic [NB-1:0]                 rows_eff;
    logic [NB-1:0]                 cols_eff;
    logic                          col_end;
    logic                          row_end;
    logic                          s0_last;
    logic                          accept;
    logic                          push;
    logic                          pop;
    logic [QB-1:0]                 q_after_pop;
    logic [QB:0]                   q_need;
    logic [SB-1:0]                 ram_rdata;
    logic [SB-1:0]                 up_best;
    logic [SB-1:0]                 base_best;
    logic [SB:0]                   sum_wide;
    logic [SB-1:0]                 s1_best;

    // ------------------------------------------------------------------
    // Grid position and input handshake.
    // ------------------------------------------------------------------
    assign rows_eff = gmps_pkg::eff_count(r_row_count, NB'(gmps_pkg::MAX_ROWS));
    assign cols_eff = gmps_pkg::eff_count(r_col_count, NB'(gmps_pkg::MAX_COLUMNS));

    assign col_end = ((NB + 1)'(r_col) + (NB + 1)'(1)) >= (NB + 1)'(cols_eff);
    assign row_end = ((NB + 1)'(r_row) + (NB + 1)'(1)) >= (NB + 1)'(rows_eff);
    assign s0_last = col_end && row_end;

    // A new cell is refused only when its result, with the ones already in
    // flight, could not fit in the queue.
    assign push   = r_s1.valid && r_s1.last;
    assign pop    = (r_q_count != '0) && !i_stall;
    assign q_need = (QB + 1)'(r_q_count) + (QB + 1)'(push) + (QB + 1)'(s0_last);
    assign o_stall = q_need > (QB + 1)'(QD);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (accept) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + RB'(1);
            end else begin
                n_col = r_col + CB'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Row buffer: read at accept, written back in the following cycle.
    // ------------------------------------------------------------------
    gmps_ram #(
        .WIDTH (SB),
        .DEPTH (gmps_pkg::MAX_COLUMNS)
    ) u_row_best (
        .i_clk   (i_clk),
        .i_we    (r_s1.valid),
        .i_waddr (r_s1.addr),
        .i_wdata (s1_best),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_s1           = r_s1;
        n_s1.valid     = accept;
        if (accept) begin
            n_s1.value     = i_gift_value;
            n_s1.addr      = r_col;
            n_s1.first_row = (r_row == '0);
            n_s1.first_col = (r_col == '0);
            n_s1.last      = s0_last;
            // The entry being written this cycle is read back before the
            // write lands; take the freshly computed sum instead.
            n_s1.fwd       = r_s1.valid && (r_s1.addr == r_col);
        end
    end

    assign up_best = r_s1.fwd ? r_last_best : ram_rdata;

    always_comb begin
        if (r_s1.first_row && r_s1.first_col) begin
            base_best = '0;
        end else if (r_s1.first_row) begin
            base_best = r_last_best;
        end else if (r_s1.first_col) begin
            base_best = up_best;
        end else begin
            base_best = (up_best > r_last_best) ? up_best : r_last_best;
        end
        sum_wide = (SB + 1)'(base_best) + (SB + 1)'(r_s1.value);
        s1_best  = sum_wide[SB] ? gmps_pkg::SUM_MAX : sum_wide[SB-1:0];
    end

    // ------------------------------------------------------------------
    // Result queue.
    // ------------------------------------------------------------------
    assign q_after_pop = r_q_count - QB'(pop);

    always_comb begin
        for (int i = 0; i < QD; i++) begin
            if (pop && (i < QD - 1)) begin
                n_q[i] = r_q[(i + 1) % QD];
            end else begin
                n_q[i] = r_q[i];
            end
            if (push && (QB'(i) == q_after_pop)) begin
                n_q[i] = s1_best;
            end
        end
        n_q_count = q_after_pop + QB'(push);
    end

    assign o_valid      = r_q_count != '0;
    assign o_best_total = r_q[0];

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= gmps_pkg::CFG_BITS'(1);
            r_col_count <= gmps_pkg::CFG_BITS'(1);
            r_row       <= '0;
            r_col       <= '0;
            r_s1        <= '0;
            r_q_count   <= '0;
        end else begin
            r_row       <= n_row;
            r_col       <= n_col;
            r_s1        <= n_s1;
            r_q_count   <= n_q_count;
            if (i_cfg_we) begin
                case (gmps_pkg::t_cfg_reg'(i_cfg_index))
                    gmps_pkg::REG_ROW_COUNT: begin
                        r_row_count <= i_cfg_data;
                    end
                    gmps_pkg::REG_COLUMN_COUNT: begin
                        r_col_count <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
                r_row <= '0;
                r_col <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1.valid) begin
            r_last_best <= s1_best;
        end
        for (int i = 0; i < QD; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_fwd_needs_prior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1.valid && r_s1.fwd |-> $past(r_s1.valid))
        else $error("forwarding selected without a write-back in the prior cycle");

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_q_count != QB'(QD)) || pop)
        else $error("result pushed into a full queue");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && s0_last |=> push)
        else $error("last cell of a grid did not produce a result");

    a_best_covers_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1.valid |-> s1_best >= SB'(r_s1.value))
        else $error("path sum below the cell value");

endmodule
